// ===== hdl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: sizes, status codes and
// the controller-to-datapath command and status structs. No dependencies.
package ffha_pkg;
   localparam int HeapBytes = 1048576;
   localparam int HeaderBytes = 16;
   localparam int MaxSegments = 64;
   localparam int SplitSlack = 8;
   localparam int AddrW = 20;
   localparam int SizeW = 21;
   localparam int IdxW = $clog2(MaxSegments);
   localparam int CntW = $clog2(MaxSegments + 1);
   localparam int EntW = 2 * AddrW + 1;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_ZERO = 3'd1;
   localparam logic [2:0] ST_BIG = 3'd2;
   localparam logic [2:0] ST_NOFIT = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_NULL = 3'd5;

   typedef struct packed {
      logic [AddrW-1:0] start;
      logic [AddrW-1:0] size;
      logic free;
   } seg_type;

   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_READ = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;

   typedef struct packed {
      logic [2:0] op;
      logic [IdxW-1:0] rd_idx;
      logic [IdxW-1:0] wr_idx;
      seg_type wr_data;
   } cmd_type;

   typedef struct packed {
      seg_type rd_data;
   } stat_type;
endpackage

// ===== hdl/ffha_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input logic clock,
   input logic we,
   input logic [$clog2(Depth)-1:0] waddr,
   input logic [Width-1:0] wdata,
   input logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0] rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== hdl/ffha_datapath.sv =====
// Datapath of the allocator: the segment table memory, driven by commands
// from the controller. Depends on ffha_pkg and ffha_ram.
module ffha_datapath import ffha_pkg::*; (
   input logic clock,
   input cmd_type cmd,
   output stat_type stat
);
   logic [EntW-1:0] rdata;

   ffha_ram #(.Width(EntW), .Depth(MaxSegments)) u_ram (
      .clock(clock),
      .we(cmd.op == OP_WRITE),
      .waddr(cmd.wr_idx),
      .wdata(cmd.wr_data),
      .raddr(cmd.rd_idx),
      .rdata(rdata)
   );

   assign stat.rd_data = seg_type'(rdata);
endmodule

// ===== hdl/ffha_ctrl.sv =====
// Controller of the allocator: scans, splits and merges the segment table
// through the datapath. Depends on ffha_pkg.
module ffha_ctrl import ffha_pkg::*; (
   input logic clock,
   input logic reset,
   input logic go,
   input logic func,
   input logic [SizeW-1:0] req_size,
   input logic [AddrW-1:0] req_addr,
   output logic busy,
   output logic done,
   output logic [AddrW-1:0] res_addr,
   output logic [2:0] res_status,
   output cmd_type cmd,
   input stat_type stat
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_INIT = 4'd1;
   localparam logic [3:0] S_SCAN = 4'd2;
   localparam logic [3:0] S_SHUP = 4'd3;
   localparam logic [3:0] S_SPLIT = 4'd4;
   localparam logic [3:0] S_FNEXT = 4'd5;
   localparam logic [3:0] S_FPREV = 4'd6;
   localparam logic [3:0] S_MWRITE = 4'd7;
   localparam logic [3:0] S_SHDN = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] ptr_ff, ptr_in;
   logic [IdxW-1:0] hit_ff, hit_in;
   logic [CntW-1:0] rmv_ff, rmv_in;
   logic rvalid_ff, rvalid_in;
   logic [IdxW-1:0] ridx_ff, ridx_in;
   logic func_ff, func_in;
   logic [SizeW-1:0] size_ff, size_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   seg_type hold_ff, hold_in;
   seg_type prev_ff, prev_in;
   logic pfree_ff, pfree_in;
   logic [AddrW-1:0] res_addr_ff, res_addr_in;
   logic [2:0] res_st_ff, res_st_in;
   logic second_ff, second_in;
   seg_type rd;
   logic [AddrW:0] sz_hdr;
   logic [AddrW:0] payload;
   logic [CntW-1:0] ridx_next;
   logic hit;

   assign rd = stat.rd_data;
   assign busy = state_ff != S_IDLE;
   assign done = state_ff == S_DONE;
   assign res_addr = res_addr_ff;
   assign res_status = res_st_ff;
   assign sz_hdr = size_ff[AddrW:0] + (AddrW+1)'(HeaderBytes);
   assign payload = {1'b0, rd.start} + (AddrW+1)'(HeaderBytes);
   assign ridx_next = CntW'(ridx_ff) + CntW'(1);
   assign hit = rvalid_ff && (func_ff ? (payload == {1'b0, addr_ff}) :
      (rd.free && {1'b0, rd.size} >= size_ff));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      hit_in = hit_ff;
      rmv_in = rmv_ff;
      rvalid_in = 1'b0;
      ridx_in = ridx_ff;
      func_in = func_ff;
      size_in = size_ff;
      addr_in = addr_ff;
      hold_in = hold_ff;
      prev_in = prev_ff;
      pfree_in = pfree_ff;
      res_addr_in = res_addr_ff;
      res_st_in = res_st_ff;
      second_in = second_ff;
      cmd = '0;
      case (state_ff)
         S_INIT: begin
            cmd.op = OP_WRITE;
            cmd.wr_idx = '0;
            cmd.wr_data = '{start: '0,
               size: AddrW'(HeapBytes - HeaderBytes), free: 1'b1};
            count_in = CntW'(1);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (go) begin
               func_in = func;
               size_in = req_size;
               addr_in = req_addr;
               res_addr_in = '0;
               res_st_in = ST_OK;
               ptr_in = '0;
               pfree_in = 1'b0;
               second_in = 1'b0;
               state_in = S_SCAN;
               if (!func && req_size == '0) begin
                  res_st_in = ST_ZERO;
                  state_in = S_DONE;
               end else if (!func && req_size > SizeW'(HeapBytes)) begin
                  res_st_in = ST_BIG;
                  state_in = S_DONE;
               end else if (func && req_addr == '0) begin
                  res_st_in = ST_NULL;
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // Reads stream one entry a cycle; each returned entry is checked as it arrives.
            if (hit) begin
               hit_in = ridx_ff;
               if (!func_ff) begin
                  res_addr_in = payload[AddrW-1:0];
                  hold_in = rd;
                  if ({1'b0, rd.size} >= sz_hdr + (AddrW+1)'(SplitSlack) &&
                        count_ff < CntW'(MaxSegments)) begin
                     ptr_in = count_ff;
                     state_in = S_SHUP;
                  end else begin
                     cmd.op = OP_WRITE;
                     cmd.wr_idx = ridx_ff;
                     cmd.wr_data = '{start: rd.start, size: rd.size, free: 1'b0};
                     state_in = S_DONE;
                  end
               end else begin
                  hold_in = '{start: rd.start, size: rd.size, free: 1'b1};
                  pfree_in = (ridx_ff != '0) && prev_ff.free;
                  if (ridx_next < count_ff) begin
                     cmd.op = OP_READ;
                     cmd.rd_idx = IdxW'(ridx_next);
                     rvalid_in = 1'b1;
                  end
                  state_in = S_FNEXT;
               end
            end else begin
               if (rvalid_ff) prev_in = rd;
               if (ptr_ff < count_ff) begin
                  cmd.op = OP_READ;
                  cmd.rd_idx = IdxW'(ptr_ff);
                  ridx_in = IdxW'(ptr_ff);
                  rvalid_in = 1'b1;
                  ptr_in = ptr_ff + CntW'(1);
               end else if (!rvalid_ff) begin
                  res_st_in = func_ff ? ST_UNKNOWN : ST_NOFIT;
                  state_in = S_DONE;
               end
            end
         end
         S_SHUP: begin
            // Entries above the hit move up by one, from the top down.
            if (ptr_ff > CntW'(hit_ff) + CntW'(1)) begin
               cmd.op = OP_READ;
               cmd.rd_idx = IdxW'(ptr_ff - CntW'(1));
               ridx_in = IdxW'(ptr_ff - CntW'(1));
               rvalid_in = 1'b1;
               ptr_in = ptr_ff - CntW'(1);
            end else begin
               state_in = S_SPLIT;
            end
            if (rvalid_ff) begin
               cmd.op = OP_WRITE;
               cmd.wr_idx = IdxW'(ridx_next);
               cmd.wr_data = rd;
            end
         end
         S_SPLIT: begin
            if (!second_ff) begin
               cmd.op = OP_WRITE;
               cmd.wr_idx = IdxW'(CntW'(hit_ff) + CntW'(1));
               cmd.wr_data = '{start: hold_ff.start + AddrW'(sz_hdr),
                  size: hold_ff.size - AddrW'(sz_hdr), free: 1'b1};
               second_in = 1'b1;
            end else begin
               cmd.op = OP_WRITE;
               cmd.wr_idx = hit_ff;
               cmd.wr_data = '{start: hold_ff.start, size: size_ff[AddrW-1:0],
                  free: 1'b0};
               count_in = count_ff + CntW'(1);
               second_in = 1'b0;
               state_in = S_DONE;
            end
         end
         S_FNEXT: begin
            rmv_in = '0;
            state_in = S_FPREV;
            if (rvalid_ff && rd.free) begin
               hold_in.size = hold_ff.size + AddrW'(HeaderBytes) + rd.size;
               rmv_in = CntW'(1);
            end
         end
         S_FPREV: begin
            state_in = S_MWRITE;
            if (pfree_ff) begin
               hold_in = '{start: prev_ff.start,
                  size: prev_ff.size + AddrW'(HeaderBytes) + hold_ff.size,
                  free: 1'b1};
               hit_in = hit_ff - IdxW'(1);
               rmv_in = rmv_ff + CntW'(1);
            end
         end
         S_MWRITE: begin
            cmd.op = OP_WRITE;
            cmd.wr_idx = hit_ff;
            cmd.wr_data = hold_ff;
            ptr_in = CntW'(hit_ff) + CntW'(1) + rmv_ff;
            state_in = (rmv_ff == '0) ? S_DONE : S_SHDN;
         end
         S_SHDN: begin
            // Entries above the removed ones move down, from the bottom up.
            if (ptr_ff < count_ff) begin
               cmd.op = OP_READ;
               cmd.rd_idx = IdxW'(ptr_ff);
               ridx_in = IdxW'(ptr_ff);
               rvalid_in = 1'b1;
               ptr_in = ptr_ff + CntW'(1);
            end else begin
               count_in = count_ff - rmv_ff;
               state_in = S_DONE;
            end
            if (rvalid_ff) begin
               cmd.op = OP_WRITE;
               cmd.wr_idx = IdxW'(CntW'(ridx_ff) - rmv_ff);
               cmd.wr_data = rd;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         count_ff <= '0;
         rvalid_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rvalid_ff <= rvalid_in;
         second_ff <= second_in;
      end
      ptr_ff <= ptr_in;
      hit_ff <= hit_in;
      rmv_ff <= rmv_in;
      ridx_ff <= ridx_in;
      func_ff <= func_in;
      size_ff <= size_in;
      addr_ff <= addr_in;
      hold_ff <= hold_in;
      prev_ff <= prev_in;
      pfree_ff <= pfree_in;
      res_addr_ff <= res_addr_in;
      res_st_ff <= res_st_in;
   end
endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing; top level with stream ports.
// The time from the accepted transfer to rsp_tvalid is set by the table
// scan and the entry shifts, one entry a cycle.
// One request at a time; the next is accepted after the result transfer.
// Synchronous active-high reset; after reset the init state re-seeds entry 0.
// Depends on ffha_pkg, ffha_ctrl and ffha_datapath.
module first_fit_heap_allocator import ffha_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // tdata: request_size [20:0], block_address [40:21]
   input logic [47:0] req_tdata,
   // tuser: func
   input logic req_tuser,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // tdata: result_address [19:0], status [22:20]
   output logic [23:0] rsp_tdata
);
   cmd_type cmd;
   stat_type stat;
   logic busy, done;
   logic [AddrW-1:0] res_addr;
   logic [2:0] res_status;
   logic rsp_valid_ff;
   logic [23:0] rsp_data_ff;
   logic go;

   assign req_tready = !busy && !rsp_valid_ff;
   assign go = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   ffha_ctrl u_ctrl (
      .clock(clock), .reset(reset), .go(go), .func(req_tuser),
      .req_size(req_tdata[20:0]), .req_addr(req_tdata[40:21]),
      .busy(busy), .done(done), .res_addr(res_addr), .res_status(res_status),
      .cmd(cmd), .stat(stat)
   );

   ffha_datapath u_dp (.clock(clock), .cmd(cmd), .stat(stat));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done) rsp_data_ff <= {1'b0, res_status, res_addr};
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("accept while busy");
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid) else $error("result lost");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:20] <= ST_NULL) else $error("bad status");
endmodule
